>>> rtl/first_fit_aligned_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// first_fit_aligned_allocator_top_defines
// Assertion helper macros for the allocator.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_TOP_DEFINES_SVH

// Clocked assertion with synchronous active-low reset
`define FFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, checked also during reset
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/ffa_pkg.sv
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit aligned allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int MAX_FREE_ENTRIES = 64;
    localparam int IDX_W = $clog2(MAX_FREE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_FREE_ENTRIES + 1);
    localparam logic [31:0] CHUNK_RESET = 32'd268435456;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [31:0] req_align;
        logic [31:0] free_offset;
        logic [31:0] free_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] blk_offset;
        logic [31:0] blk_size;
        logic [31:0] allocated_bytes;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic init;       // rebuild list from chunk size
        logic load;       // capture request
        logic rd;         // read entry r_idx+1 for the shift-down
        logic div_start;  // start offset % align
        logic eval;       // evaluate fit of read entry
        logic next;       // advance scan index
        logic take;       // remove hit entry, begin shift
        logic shift;      // one shift step
        logic append_rem; // append remainder if any
        logic append_free;// append freed block
        logic done_ok;    // result: alloc ok
        logic done_fail;  // result: no fit
        logic done_free;  // result: free ok / full
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic scan_end;   // r_idx reached count
        logic div_done;
        logic fit;
        logic shift_end;
        logic list_full;
    } t_sts;

endpackage

>>> rtl/ffa_div.sv
// ---------------------------------------------------------------------------
// ffa_div
// Radix-2 restoring remainder unit, 32-bit dividend and divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic [31:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_sh;

    always_comb begin
        w_sh   = {r_rem[31:0], r_num[31]};
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = 33'd0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];

endmodule

>>> rtl/ffa_datapath.sv
// ---------------------------------------------------------------------------
// ffa_datapath
// Free-list memory, scan index, fit test, shift-down and append.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_aligned_allocator_top_defines.svh"

module ffa_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  ffa_pkg::t_req i_req,
    input  ffa_pkg::t_cmd i_cmd,
    output ffa_pkg::t_sts o_sts,
    output ffa_pkg::t_rsp o_rsp
);

    localparam int IW = ffa_pkg::IDX_W;
    localparam int CW = ffa_pkg::CNT_W;

    logic [63:0] mem [ffa_pkg::MAX_FREE_ENTRIES];
    logic [63:0] r_rdata;

    logic [31:0]   r_chunk;
    ffa_pkg::t_req r_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_total;
    logic          r_fit;
    logic [31:0]   r_aoff, r_left;
    ffa_pkg::t_rsp r_rsp;

    logic [31:0] w_align, w_rem, w_pad, w_len;
    logic        w_div_done;
    logic [32:0] w_sum;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [63:0]   w_wdata;
    logic [IW-1:0] w_raddr;

    assign w_align = (r_req.req_align == 32'd0) ? 32'd1 : r_req.req_align;

    ffa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rdata[63:32]),
        .i_den   (w_align),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    assign w_pad = (w_rem == 32'd0) ? 32'd0 : w_align - w_rem;
    assign w_len = r_rdata[31:0] - w_pad;
    assign w_sum = {1'b0, r_total} + {1'b0, r_req.req_size};

    // single read port: shift-down reads idx+1, otherwise idx
    always_comb begin
        w_raddr = r_idx[IW-1:0];
        if (i_cmd.rd) w_raddr = r_idx[IW-1:0] + IW'(1);
    end

    // single write port; entry 0 is loaded while reset is held
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_wdata = r_rdata;
        n_count = r_count;
        if (!i_rst_n) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {32'd0, ffa_pkg::CHUNK_RESET};
            n_count = CW'(1);
        end else if (i_cfg_we) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {32'd0, i_cfg_wdata};
            n_count = CW'(1);
        end else if (i_cmd.init) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {32'd0, r_chunk};
            n_count = CW'(1);
        end else if (i_cmd.shift) begin
            w_we = 1'b1;
        end else if (i_cmd.take) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.append_rem) begin
            if (r_left != 32'd0 && r_count != CW'(ffa_pkg::MAX_FREE_ENTRIES)) begin
                w_we    = 1'b1;
                w_waddr = r_count[IW-1:0];
                w_wdata = {r_aoff + r_req.req_size, r_left};
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.append_free) begin
            if (r_count != CW'(ffa_pkg::MAX_FREE_ENTRIES)) begin
                w_we    = 1'b1;
                w_waddr = r_count[IW-1:0];
                w_wdata = {r_req.free_offset, r_req.free_size};
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= ffa_pkg::CHUNK_RESET;
            r_count <= CW'(1);
            r_total <= 32'd0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) r_chunk <= i_cfg_wdata;
            r_count <= n_count;
            if (i_cmd.load) r_idx <= '0;
            else if (i_cmd.next || i_cmd.shift) r_idx <= r_idx + CW'(1);
            if (i_cmd.done_ok)
                r_total <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        end
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.eval) begin
            r_fit  <= ((w_rem == 32'd0) || (r_rdata[31:0] > w_pad))
                      && (w_len >= r_req.req_size);
            r_aoff <= r_rdata[63:32] + w_pad;
            r_left <= w_len - r_req.req_size;
        end
        if (i_cmd.done_ok)
            r_rsp <= '{ffa_pkg::ST_OK, r_aoff, r_req.req_size,
                       w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0]};
        else if (i_cmd.done_fail)
            r_rsp <= '{ffa_pkg::ST_NO_FIT, 32'd0, 32'd0, r_total};
        else if (i_cmd.done_free)
            r_rsp <= '{(r_count == CW'(ffa_pkg::MAX_FREE_ENTRIES)) ?
                       ffa_pkg::ST_LIST_FULL : ffa_pkg::ST_OK, 32'd0, 32'd0, r_total};
    end

    assign o_sts.is_free   = r_req.func == ffa_pkg::FUNC_FREE;
    assign o_sts.scan_end  = r_idx >= r_count;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.fit       = r_fit;
    // count already dropped: entry idx takes idx+1 while idx < count
    assign o_sts.shift_end = r_idx >= r_count;
    assign o_sts.list_full = r_count == CW'(ffa_pkg::MAX_FREE_ENTRIES);
    assign o_rsp = r_rsp;

    `FFA_ASSERT(a_count_range, r_count <= CW'(ffa_pkg::MAX_FREE_ENTRIES), "count overflow")
    `FFA_ASSERT(a_count_nonzero_after_init, $past(i_cmd.init) |-> r_count == CW'(1), "init count")
    `FFA_ASSERT(a_one_result, $countones({i_cmd.done_ok, i_cmd.done_fail, i_cmd.done_free}) <= 1, "two results")

endmodule

>>> rtl/ffa_ctrl.sv
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for scan, fit test, entry removal and append.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_aligned_allocator_top_defines.svh"

module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ffa_pkg::t_sts i_sts,
    output ffa_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_APP   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_TAKE  = 4'd10;
    localparam logic [3:0] S_SHRD  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_strobe, n_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_free) begin
                    o_cmd.append_free = 1'b1;
                    o_cmd.done_free   = 1'b1;
                    n_strobe          = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.scan_end) begin
                    o_cmd.done_fail = 1'b1;
                    n_strobe        = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_RDW;
                end
            end
            S_RDW: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.fit) begin
                    n_state = S_TAKE;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_TAKE: begin
                // count drops; reads entry idx+1
                o_cmd.take = 1'b1;
                o_cmd.rd   = 1'b1;
                n_state    = S_SHRD;
            end
            S_SHRD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.shift_end ? S_APP : S_SHIFT;
            end
            S_SHIFT: begin
                // write idx with entry idx+1, read next
                o_cmd.shift = 1'b1;
                o_cmd.rd    = 1'b1;
                n_state     = S_SHRD;
            end
            S_APP: begin
                o_cmd.append_rem = 1'b1;
                o_cmd.done_ok    = 1'b1;
                n_strobe         = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;

    `FFA_ASSERT(a_strobe_in_done, o_strobe |-> r_state == S_DONE, "strobe outside done")
    `FFA_ASSERT(a_start_idle, (i_start && !o_busy) |=> r_state == S_DISP, "start lost")
    `FFA_ASSERT(a_done_returns, r_state == S_DONE |=> r_state == S_IDLE, "done stuck")

endmodule

>>> rtl/first_fit_aligned_allocator_top.sv
// ---------------------------------------------------------------------------
// first_fit_aligned_allocator_top
// First-fit free-list allocator with alignment over one memory chunk.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive i_req and raise start while busy is low; the word is
//   taken at that edge and busy rises for the whole operation.
//   Result: o_rsp is valid for one cycle with o_valid; it cannot be held.
//   Config: i_cfg_we with i_cfg_wdata writes chunk_size and rebuilds the
//   list as one entry (0, chunk_size); write only while busy is low.
// Sequence:
//   Free: the word passes S_DISP and S_DONE, result in S_DONE; a new word is taken once busy is low again.
//   Allocate: each scanned entry passes S_CHECK, S_RDW, S_DIV and S_DEC,
//   waiting in S_DIV for the serial remainder unit (offset % alignment,
//   one bit a cycle). Removing the hit entry shifts the tail down through
//   the single read and write ports, one entry per S_SHRD/S_SHIFT pass;
//   the result comes in the last busy cycle.
// Reset: list holds (0, 268435456), allocated total 0; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_aligned_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ffa_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    output logic          o_valid,
    output ffa_pkg::t_rsp o_rsp
);

    ffa_pkg::t_cmd w_cmd;
    ffa_pkg::t_sts w_sts;

    ffa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_valid)
    );

    ffa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp       (o_rsp)
    );

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the first-fit aligned allocator against its own model of the free
// list: directed corner words, then random phases, each started by a
// chunk_size write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 40000;

    class alloc_scoreboard;
        logic [31:0]   chunk;
        logic [31:0]   offs [ffa_pkg::MAX_FREE_ENTRIES];
        logic [31:0]   lens [ffa_pkg::MAX_FREE_ENTRIES];
        int            count;
        logic [31:0]   total;
        ffa_pkg::t_rsp pending [$];
        int            n_err;
        int            n_checked;
        int            n_full;
        int            n_nofit;

        function void rebuild(logic [31:0] value);
            chunk = value;
            for (int i = 0; i < ffa_pkg::MAX_FREE_ENTRIES; i++) begin
                offs[i] = '0;
                lens[i] = '0;
            end
            lens[0] = value;
            count = 1;
        endfunction

        function void clear();
            total = '0;
            n_err = 0;
            n_checked = 0;
            rebuild(ffa_pkg::CHUNK_RESET);
        endfunction

        // predict the result of an accepted request word
        function void note_request(ffa_pkg::t_req r);
            ffa_pkg::t_rsp e;
            longint unsigned a, off, len, rem, pad, sz, aoff, t;
            e = '0;
            if (r.func == ffa_pkg::FUNC_ALLOC) begin
                a  = (r.req_align == 0) ? 1 : r.req_align;
                sz = r.req_size;
                e.status = ffa_pkg::ST_NO_FIT;
                for (int i = 0; i < count; i++) begin
                    off = offs[i];
                    len = lens[i];
                    rem = off % a;
                    pad = 0;
                    if (rem != 0) begin
                        pad = a - rem;
                        if (len <= pad) continue;
                        len -= pad;
                    end
                    if (len >= sz) begin
                        aoff = off + pad;
                        for (int j = i; j + 1 < count; j++) begin
                            offs[j] = offs[j+1];
                            lens[j] = lens[j+1];
                        end
                        count--;
                        if (len != sz && count < ffa_pkg::MAX_FREE_ENTRIES) begin
                            offs[count] = 32'(aoff + sz);
                            lens[count] = 32'(len - sz);
                            count++;
                        end
                        e.status = ffa_pkg::ST_OK;
                        e.blk_offset = 32'(aoff);
                        e.blk_size = 32'(sz);
                        t = longint'(total) + sz;
                        total = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(t);
                        break;
                    end
                end
                if (e.status == ffa_pkg::ST_NO_FIT) n_nofit++;
            end else if (count >= ffa_pkg::MAX_FREE_ENTRIES) begin
                e.status = ffa_pkg::ST_LIST_FULL;
                n_full++;
            end else begin
                offs[count] = r.free_offset;
                lens[count] = r.free_size;
                count++;
            end
            e.allocated_bytes = total;
            pending = {pending, e};
        endfunction

        function void check_result(ffa_pkg::t_rsp got);
            ffa_pkg::t_rsp e;
            n_checked++;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.blk_offset !== e.blk_offset ||
                got.blk_size !== e.blk_size ||
                got.allocated_bytes !== e.allocated_bytes) begin
                n_err++;
                if (n_err <= 10)
                    $display({"mismatch: exp st=%0d off=%h size=%h total=%h, ",
                              "got st=%0d off=%h size=%h total=%h"},
                             e.status, e.blk_offset, e.blk_size, e.allocated_bytes,
                             got.status, got.blk_offset, got.blk_size,
                             got.allocated_bytes);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ffa_pkg::t_req i_req = '0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic o_valid;
    ffa_pkg::t_rsp o_rsp;

    alloc_scoreboard sb;
    int idle_cycles = 0;
    bit allow_gaps = 1'b1;

    always #4 i_clk = ~i_clk;

    first_fit_aligned_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_rsp(o_rsp)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_rsp);
        if (i_rst_n && (o_valid || (start && !busy))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(ffa_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
        if (allow_gaps && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_alloc(logic [31:0] sz, logic [31:0] al);
        ffa_pkg::t_req r;
        r = '0;
        r.func = ffa_pkg::FUNC_ALLOC;
        r.req_size = sz;
        r.req_align = al;
        r.free_offset = $urandom;
        r.free_size = $urandom;
        send_word(r);
    endtask

    task automatic send_free(logic [31:0] off, logic [31:0] sz);
        ffa_pkg::t_req r;
        r = '0;
        r.func = ffa_pkg::FUNC_FREE;
        r.req_size = $urandom;
        r.req_align = $urandom;
        r.free_offset = off;
        r.free_size = sz;
        send_word(r);
    endtask

    // write chunk_size once every result is in and the block is quiet
    task automatic write_chunk(logic [31:0] value);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.rebuild(value);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= $urandom;
    endtask

    function automatic logic [31:0] pick_align();
        case ($urandom_range(5))
            0: return 0;
            1: return 1;
            2: return 32'd1 << $urandom_range(12);
            3: return $urandom_range(100, 1);
            4: return $urandom;
            default: return 32'd1 << $urandom_range(31);
        endcase
    endfunction

    task automatic random_phase(int n, int free_weight, logic [31:0] chunk);
        logic [31:0] span;
        span = (chunk > 32'h0010_0000) ? 32'h0010_0000 : chunk;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < free_weight) begin
                if ($urandom_range(3) == 0) send_free($urandom, $urandom);
                else send_free($urandom_range(chunk), $urandom_range(span));
            end else begin
                case ($urandom_range(7))
                    0: send_alloc($urandom, pick_align());
                    1: send_alloc(0, pick_align());
                    default: send_alloc($urandom_range(span >> 4), pick_align());
                endcase
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_alloc(0, 0);
        send_alloc(32'hFFFF_FFFF, 1);
        send_alloc(100, 0);
        send_alloc(1, 32'hFFFF_FFFF);
        send_alloc(0, 3);                   // zero size, padded to an aligned offset
        send_alloc(16, 4096);
        send_free(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_free(0, 0);
        send_alloc(32'hFFFF_FFFF, 32'h8000_0000);
        send_free(32'hFFFF_FFF0, 32'h100);
        send_alloc(32'h20, 32'h10);         // first entry is already aligned and fits
        write_chunk(32'hFFFF_FFFF);
        send_alloc(32'hFFFF_FFFF, 0);
        send_alloc(32'hFFFF_FFFF, 0);       // fails, nothing left
        send_free(0, 32'hFFFF_FFFF);
        send_alloc(32'hFFFF_FFFF, 1);       // total saturates
        send_alloc(5, 2);
        write_chunk(1);
        send_alloc(1, 1);
        send_alloc(0, 1);

        write_chunk(ffa_pkg::CHUNK_RESET);
        random_phase(150, 85, ffa_pkg::CHUNK_RESET);  // drives the list to full
        write_chunk(32'd4096);
        random_phase(150, 40, 32'd4096);
        write_chunk($urandom);
        random_phase(150, 50, sb.chunk);
        write_chunk(32'd1);
        random_phase(100, 50, 32'd1);
        write_chunk(32'hFFFF_FFFF);
        random_phase(100, 45, 32'hFFFF_FFFF);
        allow_gaps = 1'b0;
        random_phase(100, 50, 32'hFFFF_FFFF);

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d results over several chunk sizes, %0d no-fit, %0d list-full",
                 sb.n_checked, sb.n_nofit, sb.n_full);
        $display("mismatches: %0d", sb.n_err);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
